// ----- design/vcme_pkg.sv -----
// Shared types, constants and the face table of the voxel cube mesh emitter.
package vcme_pkg;

   // Field widths.
   localparam int CFG_W       = 9;
   localparam int POS_W       = 9;
   localparam int COLOR_W     = 8;
   localparam int VIS_W       = 25;
   localparam int INDEX_W     = 27;
   localparam int FACE_OFS_W  = 3;
   localparam int CSR_IDX_W   = 2;

   // Volume and record constants.
   localparam int MAX_DIM_DEFAULT = 256;
   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = '1;
   localparam int CORNERS     = 8;
   localparam int TRI_INDICES = 36;
   localparam int RECORDS     = CORNERS + TRI_INDICES;
   localparam int STEP_W      = $clog2(RECORDS);
   localparam int JOB_DEPTH   = 2;

   // Record kinds.
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_GRID_DEPTH  = 2'd2
   } csr_index_type;

   // One opaque voxel waiting to be expanded into records.
   typedef struct packed {
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [VIS_W-1:0]   visible;
   } job_type;

   // Corner offset of each triangle index, six per cube face.
   function automatic logic [FACE_OFS_W-1:0] face_offset(input logic [STEP_W-1:0] idx);
      logic [FACE_OFS_W-1:0] ofs;
      case (idx)
         6'd0:  ofs = 3'd0;  6'd1:  ofs = 3'd1;  6'd2:  ofs = 3'd2;
         6'd3:  ofs = 3'd3;  6'd4:  ofs = 3'd1;  6'd5:  ofs = 3'd2;
         6'd6:  ofs = 3'd4;  6'd7:  ofs = 3'd5;  6'd8:  ofs = 3'd6;
         6'd9:  ofs = 3'd7;  6'd10: ofs = 3'd5;  6'd11: ofs = 3'd6;
         6'd12: ofs = 3'd2;  6'd13: ofs = 3'd3;  6'd14: ofs = 3'd6;
         6'd15: ofs = 3'd7;  6'd16: ofs = 3'd3;  6'd17: ofs = 3'd6;
         6'd18: ofs = 3'd0;  6'd19: ofs = 3'd1;  6'd20: ofs = 3'd4;
         6'd21: ofs = 3'd5;  6'd22: ofs = 3'd1;  6'd23: ofs = 3'd4;
         6'd24: ofs = 3'd1;  6'd25: ofs = 3'd3;  6'd26: ofs = 3'd5;
         6'd27: ofs = 3'd7;  6'd28: ofs = 3'd3;  6'd29: ofs = 3'd5;
         6'd30: ofs = 3'd0;  6'd31: ofs = 3'd2;  6'd32: ofs = 3'd4;
         6'd33: ofs = 3'd6;  6'd34: ofs = 3'd2;  6'd35: ofs = 3'd4;
         default: ofs = 3'd0;
      endcase
      return ofs;
   endfunction

endpackage

// ----- design/vcme_front.sv -----
// Front end: configuration registers, voxel position counters and opacity check.
module vcme_front #(
   parameter int MAX_DIM = vcme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [vcme_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vcme_pkg::CFG_W-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_red,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_green,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_blue,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_alpha,
   input  logic                          queue_full,
   output logic                          push,
   output vcme_pkg::job_type             push_job
);
   import vcme_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int LIM_W = ((CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W) + 1;

   logic [CFG_W-1:0] width_ff, height_ff, depth_ff;
   logic [CFG_W-1:0] width_in, height_in, depth_in;
   logic [CNT_W-1:0] col_ff, row_ff, layer_ff;
   logic [CNT_W-1:0] col_in, row_in, layer_in;
   logic [VIS_W-1:0] vis_ff, vis_in;
   logic             accept, opaque;
   logic             col_last, row_last, layer_last;

   // A zero dimension acts as one, anything above the maximum as the maximum.
   function automatic logic [LIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
      logic [LIM_W-1:0] wide;
      wide = LIM_W'(raw);
      if (wide == '0)
         return LIM_W'(1);
      else if (wide > LIM_W'(MAX_DIM))
         return LIM_W'(MAX_DIM);
      else
         return wide;
   endfunction

   // Configuration writes; an unknown index is ignored.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  width_in  = csr_data;
            CSR_GRID_HEIGHT: height_in = csr_data;
            CSR_GRID_DEPTH:  depth_in  = csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign opaque    = (req_alpha == ALPHA_OPAQUE);

   // Wrap tests; a counter at or past its limit wraps on the next advance.
   assign col_last   = !((LIM_W'(col_ff) + LIM_W'(1)) < eff_dim(width_ff));
   assign row_last   = !((LIM_W'(row_ff) + LIM_W'(1)) < eff_dim(height_ff));
   assign layer_last = !((LIM_W'(layer_ff) + LIM_W'(1)) < eff_dim(depth_ff));

   // Counter advance and visible count; the end of the volume clears all.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      layer_in = layer_ff;
      vis_in   = vis_ff;
      if (accept) begin
         if (opaque)
            vis_in = vis_ff + VIS_W'(1);
         if (!col_last) begin
            col_in = col_ff + CNT_W'(1);
         end else begin
            col_in = '0;
            if (!row_last) begin
               row_in = row_ff + CNT_W'(1);
            end else begin
               row_in = '0;
               if (!layer_last) begin
                  layer_in = layer_ff + CNT_W'(1);
               end else begin
                  layer_in = '0;
                  vis_in   = '0;
               end
            end
         end
      end
   end

   // An opaque voxel is handed to the queue with its position and colour.
   assign push             = accept && opaque;
   assign push_job.pos_x   = POS_W'(col_ff);
   assign push_job.pos_y   = POS_W'(row_ff);
   assign push_job.pos_z   = POS_W'(layer_ff);
   assign push_job.red     = req_red;
   assign push_job.green   = req_green;
   assign push_job.blue    = req_blue;
   assign push_job.visible = vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         depth_ff  <= DIM_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         layer_ff  <= '0;
         vis_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         layer_ff  <= layer_in;
         vis_ff    <= vis_in;
      end
   end

endmodule

// ----- design/vcme_queue.sv -----
// Short job queue between the front end and the record generator.
module vcme_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vcme_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output vcme_pkg::job_type pop_job
);
   import vcme_pkg::*;

   localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOB_DEPTH + 1);

   job_type          entries_ff [JOB_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(JOB_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push)
         entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ----- design/vcme_back.sv -----
// Back end: expands each queued voxel into eight vertex and 36 index records.
module vcme_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  vcme_pkg::job_type              job,
   output logic                           job_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_z,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_red,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_green,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_blue,
   output logic [vcme_pkg::INDEX_W-1:0]   rsp_vertex_index,
   output logic                           rsp_last
);
   import vcme_pkg::*;

   job_type             job_ff, job_in;
   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff, kind_in, last_ff, last_in;
   logic [POS_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [COLOR_W-1:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                out_free, fire, done, load;
   logic                is_vertex;
   logic [2:0]          corner;
   logic [STEP_W-1:0]   face_step;

   // Sequencing: one record per cycle while the output register has room.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = busy_ff && out_free;
   assign done     = fire && (step_ff == STEP_W'(RECORDS - 1));
   assign load     = !busy_ff || done;
   assign job_pop  = load && job_valid;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      job_in  = job_ff;
      if (load) begin
         busy_in = job_valid;
         step_in = '0;
         if (job_valid)
            job_in = job;
      end else if (fire) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Record contents for the current step.
   assign is_vertex = (step_ff < STEP_W'(CORNERS));
   assign corner    = step_ff[2:0];
   assign face_step = step_ff - STEP_W'(CORNERS);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      if (out_free)
         rsp_valid_in = fire;
      if (fire) begin
         if (is_vertex) begin
            kind_in  = KIND_VERTEX;
            pos_x_in = job_ff.pos_x + POS_W'(corner[0]);
            pos_y_in = job_ff.pos_y + POS_W'(corner[1]);
            pos_z_in = job_ff.pos_z + POS_W'(corner[2]);
            red_in   = job_ff.red;
            green_in = job_ff.green;
            blue_in  = job_ff.blue;
            index_in = '0;
            last_in  = 1'b0;
         end else begin
            kind_in  = KIND_INDEX;
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
            index_in = {job_ff.visible[INDEX_W-FACE_OFS_W-1:0], face_offset(face_step)};
            last_in  = (step_ff == STEP_W'(RECORDS - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      kind_ff  <= kind_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      pos_z_ff <= pos_z_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_color_red    = red_ff;
   assign rsp_color_green  = green_ff;
   assign rsp_color_blue   = blue_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- design/voxel_cube_mesh_emitter_core.sv -----
// An opaque voxel passes the job queue, the job register and the output registers before
// its first record. Throughput: one record per cycle while rsp_stall is low; an opaque voxel
// holds the generator for its 44 records, so a full job queue frees only as each one ends.
// Transparent voxels are taken one per cycle while the two-entry job queue has room.
// Reset is synchronous: counters and queue clear, grid dimensions return to 16.
module voxel_cube_mesh_emitter_core #(
   parameter int MAX_DIM = vcme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [vcme_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vcme_pkg::CFG_W-1:0]     csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_red,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_green,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_blue,
   input  logic [vcme_pkg::COLOR_W-1:0]   req_alpha,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [vcme_pkg::POS_W-1:0]     rsp_pos_z,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_red,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_green,
   output logic [vcme_pkg::COLOR_W-1:0]   rsp_color_blue,
   output logic [vcme_pkg::INDEX_W-1:0]   rsp_vertex_index,
   output logic                           rsp_last
);
   import vcme_pkg::*;

   logic    push, queue_full, pop, pop_valid;
   job_type push_job, pop_job;

   // Front end: configuration, counters and opacity check.
   vcme_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .req_alpha  (req_alpha),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue.
   vcme_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   // Record generator.
   vcme_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (pop_valid),
      .job              (pop_job),
      .job_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_color_red    (rsp_color_red),
      .rsp_color_green  (rsp_color_green),
      .rsp_color_blue   (rsp_color_blue),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last)
   );

   // The final record of a voxel is always a triangle index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_INDEX)
      else $error("last marker on a vertex record");

   // Once index records have started, the run continues without gaps until its end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last && rsp_kind == KIND_INDEX
      |=> rsp_valid && rsp_kind == KIND_INDEX)
      else $error("gap inside a triangle index run");

   // A completed index run is followed by a vertex record or by nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid || rsp_kind == KIND_VERTEX)
      else $error("index record after the end of a voxel");

endmodule
